/* rtl/dma_region_table_defines.svh */
// assertion macros for the dma region table
// used by the top level only, clocked on clk_i with reset rst_ni
`ifndef DMA_REGION_TABLE_DEFINES_SVH
`define DMA_REGION_TABLE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define DRT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/drt_pkg.sv */
// types and constants for the dma region table
// no dependencies
package drt_pkg;

  localparam int unsigned SLOTS     = 16;
  localparam int unsigned IDX_W     = $clog2(SLOTS);
  localparam int unsigned CNT_W     = $clog2(SLOTS + 1);
  localparam int unsigned ID_BASE_W = 19;
  localparam int unsigned SKIP_W    = 16;
  localparam int unsigned ADDR_W    = 64;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;

  // register index of id_base
  localparam int unsigned REG_ID_BASE = 0;

  typedef enum logic [1:0] {
    REQ_ADD_NEW = 2'd0,
    REQ_ADD_ID  = 2'd1,
    REQ_REMOVE  = 2'd2,
    REQ_BOUNDS  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_ARGS = 2'd1,
    STAT_ID   = 2'd2,
    STAT_FULL = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_PROBE,
    FSM_BCHK,
    FSM_DONE
  } fsm_e;

  typedef struct packed {
    req_e              req_type;
    logic [ADDR_W-1:0] region_base;
    logic [ADDR_W-1:0] region_bytes;
    logic [KEY_W-1:0]  region_key;
    logic [ADDR_W-1:0] buf_offset;
    logic [ADDR_W-1:0] buf_length;
    logic [ADDR_W-1:0] data_offset;
    logic [ADDR_W-1:0] data_length;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic [KEY_W-1:0] assigned_id;
    logic             bounds_ok;
  } rsp_t;

  // one table entry as held in the slot memory
  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] len;
  } slot_t;

endpackage

/* rtl/dma_region_table.sv */
// dma region table: top level with slot memory, sequencer and apb register
// depends on drt_pkg and dma_region_table_defines.svh
//
// usage
//   request items enter on in_valid_i / in_ready_o with a drt_pkg::req_t payload,
//   one result item per request leaves on out_valid_o / out_ready_i as drt_pkg::rsp_t
//   the block works on one item at a time; in_ready_o is high in the idle state
//   region base and length live in a slot memory with a registered read; occupancy
//   bits, region count and probe skip sit in flip-flops
// sequence, from acceptance until out_valid_o rises
//   add with id, remove: any table change is made at acceptance, then the result is handed over
//   bounds check: one memory read of the addressed slot, then the check
//   plain add: an overlap scan from slot zero (one slot read and compared per
//   cycle, stops at the first overlap), then, unless the table is full, a probe
//   (one occupancy bit tried per cycle) until a free slot turns up
//   a new item is accepted in the cycle after the previous result is handed to the
//   output register
// stalls: the result sits in an output register; a new item is accepted while it
//   waits, and the next result is held back until the register is free
// reset: table empty, region count, probe skip and id_base cleared, no clearing
//   pass; the apb register id_base lies at byte address 0; the user must see that it is
//   written only while the block is idle, the block itself does not enforce this
`include "dma_region_table_defines.svh"

module dma_region_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  drt_pkg::req_t                 in_data_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output drt_pkg::rsp_t                 out_data_o,
  // apb register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [drt_pkg::APB_AW-1:0]    paddr,
  input  logic [drt_pkg::APB_DW-1:0]    pwdata,
  output logic [drt_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  localparam logic [drt_pkg::IDX_W-1:0] LAST_IDX = drt_pkg::IDX_W'(drt_pkg::SLOTS - 1);

  // control state
  drt_pkg::fsm_e                    state_q, state_d;
  logic [drt_pkg::SLOTS-1:0]        valid_q, valid_d;
  logic [drt_pkg::CNT_W-1:0]        count_q, count_d;
  logic [drt_pkg::SKIP_W-1:0]       skip_q, skip_d;
  logic [drt_pkg::ID_BASE_W-1:0]    id_base_q;
  logic                             out_valid_q, out_valid_d;

  // per-item working registers
  logic [drt_pkg::SKIP_W-1:0]       off_q, off_d;
  logic [drt_pkg::IDX_W-1:0]        chk_q, chk_d;
  drt_pkg::rsp_t                    res_q, res_d;
  drt_pkg::rsp_t                    out_q, out_d;
  logic [drt_pkg::ADDR_W-1:0]       base_q, bytes_q;
  logic [drt_pkg::ADDR_W:0]         end_q, buf_end_q;
  logic                             fit_q;
  logic [drt_pkg::IDX_W-1:0]        slot_q;

  // slot memory
  drt_pkg::slot_t                   mem_q [drt_pkg::SLOTS];
  drt_pkg::slot_t                   mem_rd_q;
  logic                             mem_we;
  logic [drt_pkg::IDX_W-1:0]        mem_waddr, mem_raddr;
  drt_pkg::slot_t                   mem_wdata;

  logic                             in_accept;
  logic [drt_pkg::IDX_W-1:0]        key_slot;
  logic                             full;
  logic                             overlap;
  logic [drt_pkg::ADDR_W:0]         rd_end;
  logic [drt_pkg::CNT_W-1:0]        cnt_new;
  logic [drt_pkg::KEY_W-1:0]        id_sum;
  logic [drt_pkg::IDX_W-1:0]        pidx;
  logic                             cfg_we;

  assign in_ready_o  = (state_q == drt_pkg::FSM_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;
  assign key_slot    = in_data_i.region_key[drt_pkg::IDX_W-1:0];
  assign full        = (count_q >= drt_pkg::CNT_W'(drt_pkg::SLOTS));
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // overlap test of the slot whose data came back from memory this cycle
  assign rd_end  = {1'b0, mem_rd_q.base} + {1'b0, mem_rd_q.len};
  assign overlap = valid_q[chk_q] &&
                   ((mem_rd_q.base == base_q) ||
                    !((end_q <= {1'b0, mem_rd_q.base}) || (rd_end <= {1'b0, base_q})));

  // probe candidate: id = id_base + count + 1 + offset, slot = id mod SLOTS
  assign cnt_new = count_q + drt_pkg::CNT_W'(1);
  assign id_sum  = drt_pkg::KEY_W'(id_base_q) + drt_pkg::KEY_W'(cnt_new) +
                   drt_pkg::KEY_W'(off_q);
  assign pidx    = id_sum[drt_pkg::IDX_W-1:0];

  // apb register
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready &&
                  (paddr[drt_pkg::APB_AW-1:2] == (drt_pkg::APB_AW-2)'(drt_pkg::REG_ID_BASE));
  assign prdata = (paddr[drt_pkg::APB_AW-1:2] == (drt_pkg::APB_AW-2)'(drt_pkg::REG_ID_BASE))
                  ? drt_pkg::APB_DW'(id_base_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_base_q <= '0;
    end else if (cfg_we) begin
      id_base_q <= pwdata[drt_pkg::ID_BASE_W-1:0];
    end
  end

  // sequencer: next state, table updates and memory control
  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    count_d     = count_q;
    skip_d      = skip_q;
    off_d       = off_q;
    chk_d       = chk_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mem_we      = 1'b0;
    mem_waddr   = slot_q;
    mem_wdata   = '{base: base_q, len: bytes_q};
    mem_raddr   = chk_q + drt_pkg::IDX_W'(1);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      drt_pkg::FSM_IDLE: begin
        if (in_valid_i) begin
          res_d = '{status: drt_pkg::STAT_OK, assigned_id: '0, bounds_ok: 1'b0};
          case (in_data_i.req_type)
            drt_pkg::REQ_ADD_NEW: begin
              // start the overlap scan at slot zero
              chk_d     = '0;
              mem_raddr = '0;
              state_d   = drt_pkg::FSM_SCAN;
            end
            drt_pkg::REQ_ADD_ID: begin
              if (full) begin
                res_d.status = drt_pkg::STAT_FULL;
              end else if (valid_q[key_slot]) begin
                res_d.status = drt_pkg::STAT_ID;
              end else begin
                valid_d[key_slot] = 1'b1;
                count_d           = cnt_new;
                mem_we            = 1'b1;
                mem_waddr         = key_slot;
                mem_wdata         = '{base: in_data_i.region_base,
                                      len:  in_data_i.region_bytes};
              end
              state_d = drt_pkg::FSM_DONE;
            end
            drt_pkg::REQ_REMOVE: begin
              if (!valid_q[key_slot]) begin
                res_d.status = drt_pkg::STAT_ID;
              end else begin
                valid_d[key_slot] = 1'b0;
                if (count_q != '0) begin
                  count_d = count_q - drt_pkg::CNT_W'(1);
                end
              end
              state_d = drt_pkg::FSM_DONE;
            end
            drt_pkg::REQ_BOUNDS: begin
              mem_raddr = key_slot;
              state_d   = drt_pkg::FSM_BCHK;
            end
            default: begin
              state_d = drt_pkg::FSM_DONE;
            end
          endcase
        end
      end

      drt_pkg::FSM_SCAN: begin
        if (overlap) begin
          res_d.status = drt_pkg::STAT_ARGS;
          state_d      = drt_pkg::FSM_DONE;
        end else if (chk_q == LAST_IDX) begin
          if (full) begin
            res_d.status = drt_pkg::STAT_FULL;
            state_d      = drt_pkg::FSM_DONE;
          end else begin
            off_d   = skip_q;
            state_d = drt_pkg::FSM_PROBE;
          end
        end else begin
          chk_d = chk_q + drt_pkg::IDX_W'(1);
        end
      end

      drt_pkg::FSM_PROBE: begin
        if (!valid_q[pidx]) begin
          valid_d[pidx]     = 1'b1;
          count_d           = cnt_new;
          skip_d            = off_q;
          mem_we            = 1'b1;
          mem_waddr         = pidx;
          res_d.assigned_id = id_sum;
          state_d           = drt_pkg::FSM_DONE;
        end else begin
          off_d = off_q + drt_pkg::SKIP_W'(1);
        end
      end

      drt_pkg::FSM_BCHK: begin
        if (!valid_q[slot_q]) begin
          res_d.status = drt_pkg::STAT_ID;
        end else begin
          res_d.bounds_ok = (buf_end_q <= {1'b0, mem_rd_q.len}) && fit_q;
        end
        state_d = drt_pkg::FSM_DONE;
      end

      drt_pkg::FSM_DONE: begin
        // hand the result over once the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = drt_pkg::FSM_IDLE;
        end
      end

      default: begin
        state_d = drt_pkg::FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= drt_pkg::FSM_IDLE;
      valid_q     <= '0;
      count_q     <= '0;
      skip_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      count_q     <= count_d;
      skip_q      <= skip_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working and result payload, no reset needed
  always_ff @(posedge clk_i) begin
    off_q <= off_d;
    chk_q <= chk_d;
    res_q <= res_d;
    out_q <= out_d;
    if (in_accept) begin
      base_q    <= in_data_i.region_base;
      bytes_q   <= in_data_i.region_bytes;
      end_q     <= {1'b0, in_data_i.region_base} + {1'b0, in_data_i.region_bytes};
      buf_end_q <= {1'b0, in_data_i.buf_length} + {1'b0, in_data_i.buf_offset};
      fit_q     <= ({1'b0, in_data_i.data_offset} + {1'b0, in_data_i.data_length}) <=
                   {1'b0, in_data_i.buf_length};
      slot_q    <= key_slot;
    end
  end

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    mem_rd_q <= mem_q[mem_raddr];
  end

  // region count tracks the number of occupied slots
  `DRT_ASSERT_NOW(a_count_matches, 1'b1, count_q == $countones(valid_q),
                  "region count differs from occupied slots")
  // only a successful plain add returns a nonzero id
  `DRT_ASSERT_NOW(a_id_only_ok, out_valid_o && (out_data_o.assigned_id != '0),
                  out_data_o.status == drt_pkg::STAT_OK && !out_data_o.bounds_ok,
                  "assigned id with failing status or bounds flag")
  // an accepted item always leaves idle
  `DRT_ASSERT_NEXT(a_accept_busy, in_valid_i && in_ready_o, !in_ready_o,
                   "ready still high after accepting an item")

endmodule

/* test/testbench.sv */
// self-checking testbench for dma_region_table: region add, add-with-id, remove, bounds check
// keeps its own copy of the region table; needs drt_pkg and the dma_region_table rtl
`timescale 1ns / 100ps

module testbench;
  import drt_pkg::*;

  localparam int LIMIT_CYCLES  = 1_500_000;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [APB_AW-1:0] ID_BASE_ADDR = APB_AW'(REG_ID_BASE * 4);

  logic clk_i = 1'b0;
  logic rst_ni;

  // request and result channels
  logic  in_valid_i;
  logic  in_ready_o;
  req_t  in_data_i;
  logic  out_valid_o;
  logic  out_ready_i;
  rsp_t  out_data_o;

  // register port
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  dma_region_table uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // shadow copy of the region table, advanced once per accepted item
  logic                  slot_used [SLOTS];
  logic [ADDR_W-1:0]     slot_base [SLOTS];
  logic [ADDR_W-1:0]     slot_len  [SLOTS];
  logic [CNT_W-1:0]      region_cnt;
  logic [SKIP_W-1:0]     probe_skip;
  logic [ID_BASE_W-1:0]  id_base_q;

  // results still owed by the block, oldest first
  rsp_t rsp_due [$];

  // idling controls, written by the test sequence only
  bit tx_gaps_on   = 1'b1;
  bit rx_stalls_on = 1'b1;
  int hold_cycles  = 0;
  int hold_seq     = 0;

  int mismatch_cnt = 0;
  int reg_err_cnt  = 0;
  int checked_cnt  = 0;
  int cycle_cnt    = 0;

  // what the run reached, for the closing summary
  int req_cnt      = 0;
  int added_cnt    = 0;
  int overlap_cnt  = 0;
  int full_cnt     = 0;
  int bad_id_cnt   = 0;
  int removed_cnt  = 0;
  int bounds_pass  = 0;
  int bounds_fail  = 0;
  int id_base_sets = 0;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // a + b <= c with the sum carried into a 65th bit
  function automatic logic sum_within(input logic [63:0] a, input logic [63:0] b,
                                      input logic [63:0] c);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s <= {1'b0, c};
  endfunction

  // result of one request against the shadow table; updates the table
  function automatic rsp_t table_response(input req_t r);
    rsp_t             rsp;
    logic [IDX_W-1:0] s;
    logic [CNT_W-1:0] cnt;
    logic [SKIP_W-1:0] off;
    logic [KEY_W-1:0] id;
    logic             clash;
    logic             found;
    rsp = '0;
    rsp.status = STAT_OK;
    s = r.region_key[IDX_W-1:0];
    case (r.req_type)
      REQ_ADD_NEW: begin
        clash = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_used[i] && (slot_base[i] == r.region_base ||
              !(sum_within(r.region_base, r.region_bytes, slot_base[i]) ||
                sum_within(slot_base[i], slot_len[i], r.region_base))))
            clash = 1'b1;
        end
        if (clash) begin
          rsp.status = STAT_ARGS;
        end else if (region_cnt >= SLOTS) begin
          rsp.status = STAT_FULL;
        end else begin
          // probe from the saved skip until a free slot turns up
          cnt   = region_cnt + 1'b1;
          off   = probe_skip;
          found = 1'b0;
          id    = '0;
          for (int t = 0; t < SLOTS; t++) begin
            if (!found) begin
              id = KEY_W'(id_base_q) + KEY_W'(cnt) + KEY_W'(off);
              if (!slot_used[id[IDX_W-1:0]]) found = 1'b1;
              else off = off + 1'b1;
            end
          end
          region_cnt = cnt;
          probe_skip = off;
          slot_used[id[IDX_W-1:0]] = 1'b1;
          slot_base[id[IDX_W-1:0]] = r.region_base;
          slot_len[id[IDX_W-1:0]]  = r.region_bytes;
          rsp.assigned_id = id;
        end
      end
      REQ_ADD_ID: begin
        if (region_cnt >= SLOTS) begin
          rsp.status = STAT_FULL;
        end else if (slot_used[s]) begin
          rsp.status = STAT_ID;
        end else begin
          slot_used[s] = 1'b1;
          slot_base[s] = r.region_base;
          slot_len[s]  = r.region_bytes;
          region_cnt   = region_cnt + 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (!slot_used[s]) begin
          rsp.status = STAT_ID;
        end else begin
          slot_used[s] = 1'b0;
          if (region_cnt != 0) region_cnt = region_cnt - 1'b1;
        end
      end
      default: begin
        if (!slot_used[s]) begin
          rsp.status = STAT_ID;
        end else begin
          rsp.bounds_ok = sum_within(r.buf_length, r.buf_offset, slot_len[s]) &&
                          sum_within(r.data_offset, r.data_length, r.buf_length);
        end
      end
    endcase
    return rsp;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 88) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  // random slot that is occupied (want_used) or free, -1 if there is none
  function automatic int pick_slot(input logic want_used);
    int cands [$];
    for (int i = 0; i < SLOTS; i++)
      if (slot_used[i] == want_used) cands.push_back(i);
    if (cands.size() == 0) return -1;
    return cands[$urandom_range(0, cands.size() - 1)];
  endfunction

  // add or remove item; the bounds fields carry noise
  function automatic req_t region_req(input req_e kind, input logic [63:0] base,
                                      input logic [63:0] bytes, input logic [31:0] key);
    req_t r;
    r.req_type     = kind;
    r.region_base  = base;
    r.region_bytes = bytes;
    r.region_key   = key;
    r.buf_offset   = rand64();
    r.buf_length   = rand64();
    r.data_offset  = rand64();
    r.data_length  = rand64();
    return r;
  endfunction

  // bounds check item; the region fields carry noise
  function automatic req_t bounds_req(input logic [31:0] key, input logic [63:0] bo,
                                      input logic [63:0] bl, input logic [63:0] doff,
                                      input logic [63:0] dlen);
    req_t r;
    r = region_req(REQ_BOUNDS, rand64(), rand64(), key);
    r.buf_offset  = bo;
    r.buf_length  = bl;
    r.data_offset = doff;
    r.data_length = dlen;
    return r;
  endfunction

  // mostly well-formed traffic aimed at live slots, the rest pure noise
  function automatic req_t random_request(input int add_pct);
    req_t        r;
    int          s;
    logic [63:0] hi;
    logic [63:0] len;
    r = bounds_req($urandom(), rand64(), rand64(), rand64(), rand64());
    r.region_base  = rand64();
    r.region_bytes = rand64();
    if ($urandom_range(0, 99) < add_pct) begin
      r.req_type = ($urandom_range(0, 9) < 7) ? REQ_ADD_NEW : REQ_ADD_ID;
      if ($urandom_range(0, 4) != 0) begin
        // regions packed into a few windows so that overlaps and equal bases happen
        case ($urandom_range(0, 2))
          0:       hi = 64'h0;
          1:       hi = 64'h0000_7FFF_0000_0000;
          default: hi = 64'hFFFF_FFFF_FFF0_0000;
        endcase
        r.region_base = hi | (64'($urandom_range(0, 47)) << 12);
        case ($urandom_range(0, 19))
          0, 1, 2: r.region_bytes = '0;
          3, 4, 5: r.region_bytes = rand64();
          default: r.region_bytes = 64'($urandom_range(1, 'h1800));
        endcase
      end
      if (r.req_type == REQ_ADD_ID && $urandom_range(0, 1) == 1) begin
        s = pick_slot(1'b0);
        if (s >= 0) r.region_key[IDX_W-1:0] = IDX_W'(s);
      end
    end else begin
      r.req_type = ($urandom_range(0, 99) < 40) ? REQ_REMOVE : REQ_BOUNDS;
      s = pick_slot(1'b1);
      if (s >= 0 && $urandom_range(0, 3) != 0) begin
        r.region_key[IDX_W-1:0] = IDX_W'(s);
        if (r.req_type == REQ_BOUNDS && $urandom_range(0, 5) != 0) begin
          // buffer and window near the edges of the region
          len = slot_len[s];
          r.buf_length = len >> $urandom_range(0, 6);
          r.buf_offset = len - r.buf_length;
          case ($urandom_range(0, 3))
            0:       r.buf_offset = r.buf_offset + 64'd1;
            1:       r.buf_offset = r.buf_offset >> 1;
            default: ;
          endcase
          r.data_offset = r.buf_length >> $urandom_range(0, 6);
          r.data_length = r.buf_length - r.data_offset;
          case ($urandom_range(0, 3))
            0:       r.data_length = r.data_length + 64'd1;
            1:       r.data_length = r.data_length >> 1;
            default: ;
          endcase
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // offer one item, predict its result on acceptance, then maybe idle
  task automatic send_request(input req_t r);
    rsp_t want;
    int   gap;
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (!in_ready_o);
    want = table_response(r);
    rsp_due.push_back(want);
    req_cnt++;
    case (want.status)
      STAT_ARGS: overlap_cnt++;
      STAT_FULL: full_cnt++;
      STAT_ID:   bad_id_cnt++;
      default: begin
        if (r.req_type == REQ_REMOVE) removed_cnt++;
        else if (r.req_type == REQ_BOUNDS && want.bounds_ok) bounds_pass++;
        else if (r.req_type == REQ_BOUNDS) bounds_fail++;
        else added_cnt++;
      end
    endcase
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop offering and wait until the block owes nothing
  task automatic finish_phase();
    in_valid_i <= 1'b0;
    while (rsp_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // apb write: setup, access, then back to idle
  task automatic reg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // apb read, checked against the value the register should hold
  task automatic reg_read_check(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      reg_err_cnt++;
      if (reg_err_cnt <= 10)
        $display("register read at %0d: expected %h, got %h", addr, want, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // only called while the block is idle
  task automatic set_id_base(input logic [ID_BASE_W-1:0] val);
    reg_write(ID_BASE_ADDR, APB_DW'(val));
    id_base_q = val;
    id_base_sets++;
    reg_read_check(ID_BASE_ADDR, APB_DW'(val));
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_register_access();
    reg_read_check(ID_BASE_ADDR, '0);
    set_id_base('1);
    set_id_base('0);
  endtask

  // edges of the overlap rule, id handling and the bounds sums
  task automatic test_directed_requests();
    // nothing stored yet
    send_request(bounds_req(32'h0, '0, '0, '0, '0));
    send_request(region_req(REQ_REMOVE, '1, '1, 32'hFFFF_FFFF));
    // plain adds: first region, then equal base, overlap from above and below
    send_request(region_req(REQ_ADD_NEW, 64'h1000, 64'h100, '1));
    send_request(region_req(REQ_ADD_NEW, 64'h1000, 64'h0, '0));
    send_request(region_req(REQ_ADD_NEW, 64'h10FF, 64'h1, $urandom()));
    send_request(region_req(REQ_ADD_NEW, 64'h0F00, 64'h101, $urandom()));
    // touching neighbors are fine
    send_request(region_req(REQ_ADD_NEW, 64'h1100, 64'h10, $urandom()));
    send_request(region_req(REQ_ADD_NEW, 64'h0, 64'h1000, $urandom()));
    // region at the very top, its end carries out of 64 bits
    send_request(region_req(REQ_ADD_NEW, '1, '1, $urandom()));
    // zero length inside a stored region still overlaps
    send_request(region_req(REQ_ADD_NEW, 64'h80, 64'h0, $urandom()));
    // add with id: taken slot, then a free slot at an already used base
    send_request(region_req(REQ_ADD_ID, 64'h5000, 64'h10, 32'hABCD_0001));
    send_request(region_req(REQ_ADD_ID, 64'h1000, 64'h20, 32'hFFFF_FFF0));
    // bounds against the 0x100 byte region in slot 1
    send_request(bounds_req(32'h5555_5551, 64'h80, 64'h80, 64'h40, 64'h40));
    send_request(bounds_req(32'h5555_5551, 64'h81, 64'h80, 64'h40, 64'h40));
    send_request(bounds_req(32'h5555_5551, 64'h80, 64'h80, 64'h41, 64'h40));
    send_request(bounds_req(32'h0000_0001, '0, '0, '0, '0));
    send_request(bounds_req(32'h0000_0001, '1, 64'h1, '0, '0));
    // bounds against the region with all-ones length, window sum carries out
    send_request(bounds_req(32'h0000_0004, '0, '1, 64'h1, '1));
    send_request(bounds_req(32'h0000_0004, '0, '1, '0, '1));
    // remove ignores the upper key bits; second remove finds the slot empty
    send_request(region_req(REQ_REMOVE, '0, '0, 32'h8000_0001));
    send_request(region_req(REQ_REMOVE, '0, '0, 32'h8000_0001));
    send_request(region_req(REQ_ADD_ID, 64'h6000, 64'h10, 32'h0000_0011));
    finish_phase();
    // largest id offset
    set_id_base('1);
    send_request(region_req(REQ_ADD_NEW, 64'h2000_0000, 64'h10, $urandom()));
    finish_phase();
  endtask

  // every slot taken: plain adds report full, and full beats a taken id
  task automatic test_table_full();
    int s;
    for (int i = 0; i < SLOTS; i++) begin
      if (!slot_used[i])
        send_request(region_req(REQ_ADD_ID, 64'h4000_0000 + 64'(i) * 64'h100, 64'h10,
                                {16'($urandom_range(0, 'hFFFF)), 12'h0, IDX_W'(i)}));
    end
    send_request(region_req(REQ_ADD_NEW, 64'h9000_0000, 64'h1, $urandom()));
    send_request(region_req(REQ_ADD_ID, 64'h9100_0000, 64'h1, 32'h0000_0003));
    send_request(region_req(REQ_ADD_NEW, 64'h4000_0000, 64'h1, $urandom()));
    // free one slot and let the probe find it
    s = pick_slot(1'b1);
    send_request(region_req(REQ_REMOVE, '0, '0,
                            {16'($urandom_range(0, 'hFFFF)), 12'h0, IDX_W'(s)}));
    send_request(region_req(REQ_ADD_NEW, 64'h9000_0000, 64'h1, $urandom()));
    finish_phase();
  endtask

  // result side holds off while items keep coming until the block backs up
  task automatic test_backpressure();
    tx_gaps_on  = 1'b0;
    hold_cycles = 300;
    hold_seq++;
    for (int n = 0; n < 24; n++)
      send_request(random_request(50));
    finish_phase();
    tx_gaps_on = 1'b1;
  endtask

  // phases with different add pressure and id_base settings
  task automatic test_random_phases();
    int                   add_bias [10] = '{70, 30, 90, 50, 20, 65, 85, 40, 55, 45};
    logic [ID_BASE_W-1:0] val;
    for (int p = 0; p < 10; p++) begin
      case (p)
        0:       val = '1;
        1:       val = '0;
        2:       val = ID_BASE_W'(1);
        3:       val = ID_BASE_W'(19'h40000);
        default: val = ID_BASE_W'($urandom_range(0, 19'h7FFFF));
      endcase
      set_id_base(val);
      // one phase runs flat out on both sides
      tx_gaps_on   = (p != 3);
      rx_stalls_on = (p != 3);
      for (int n = 0; n < 200; n++) begin
        send_request(random_request(add_bias[p]));
        // sender pauses until every result is back
        if (p == 5 && n == 100) finish_phase();
      end
      finish_phase();
    end
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls plus the long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall_left;
    int seen_hold;
    stall_left = 0;
    seen_hold  = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seq != seen_hold) begin
        seen_hold = hold_seq;
        out_ready_i <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (!rx_stalls_on) begin
        out_ready_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                 : $urandom_range(0, 2);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result check against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    rsp_t rsp_got;
    rsp_t rsp_want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      rsp_got = out_data_o;
      if (rsp_due.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: status %0d id %h ok %b",
                   rsp_got.status, rsp_got.assigned_id, rsp_got.bounds_ok);
      end else begin
        rsp_want = rsp_due.pop_front();
        checked_cnt++;
        if (rsp_got.status !== rsp_want.status ||
            rsp_got.assigned_id !== rsp_want.assigned_id ||
            rsp_got.bounds_ok !== rsp_want.bounds_ok) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("result %0d: expected status %0d id %h ok %b, got status %0d id %h ok %b",
                     checked_cnt, rsp_want.status, rsp_want.assigned_id, rsp_want.bounds_ok,
                     rsp_got.status, rsp_got.assigned_id, rsp_got.bounds_ok);
        end
      end
    end
  end

  // hard stop in case the block hangs
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, rsp_due.size());
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_used[i] = 1'b0;
      slot_base[i] = '0;
      slot_len[i]  = '0;
    end
    region_cnt = '0;
    probe_skip = '0;
    id_base_q  = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_access();
    test_directed_requests();
    test_table_full();
    test_backpressure();
    test_random_phases();

    $display("%0d requests, %0d results checked over %0d id_base settings",
             req_cnt, checked_cnt, id_base_sets);
    $display("adds %0d, overlap %0d, full %0d, bad id %0d, removes %0d, bounds %0d/%0d",
             added_cnt, overlap_cnt, full_cnt, bad_id_cnt, removed_cnt,
             bounds_pass, bounds_pass + bounds_fail);
    if (mismatch_cnt == 0 && reg_err_cnt == 0 && rsp_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d result mismatches, %0d register mismatches", mismatch_cnt, reg_err_cnt);
      $display("FAIL");
    end
    $finish;
  end

endmodule
